// ===== rtl/pic_pkg.sv =====
// ----------------------------------------------------------------------------
// pic_pkg
// Shared types and constants of the platform interrupt controller.
// ----------------------------------------------------------------------------
package pic_pkg;

    localparam int OFF_W   = 26;
    localparam int DATA_W  = 32;
    localparam int LVL_W   = 64;
    localparam int IDX_W   = 10;
    localparam int CTX_W   = 4;
    localparam int REQ_W   = 4;

    localparam logic [OFF_W-1:0] PENDING_BASE = 26'h0001000;
    localparam logic [OFF_W-1:0] ENABLE_BASE  = 26'h0002000;
    localparam logic [OFF_W-1:0] CONTEXT_BASE = 26'h0200000;
    localparam logic [11:0]      REG_THRESH   = 12'h000;
    localparam logic [11:0]      REG_CLAIM    = 12'h004;

    localparam logic [1:0] REQ_READ   = 2'd0;
    localparam logic [1:0] REQ_WRITE  = 2'd1;
    localparam logic [1:0] REQ_LEVELS = 2'd2;

    typedef enum logic [2:0] {
        K_NOP,
        K_ERR,
        K_LEVELS,
        K_PRIO,
        K_PEND,
        K_ENAB,
        K_THRESH,
        K_CLAIM
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic               wr;
        logic [CTX_W-1:0]   ctx;
        logic [IDX_W-1:0]   idx;
        logic [DATA_W-1:0]  data;
        logic [LVL_W-1:0]   levels;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_qchan;

endpackage

// ===== rtl/pic_if.sv =====
// ----------------------------------------------------------------------------
// pic_in_if / pic_out_if
// Request and result channels of the interrupt controller.
// ----------------------------------------------------------------------------
interface pic_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [25:0] offset;
    logic [31:0] write_data;
    logic [63:0] source_levels;

    modport source (output valid, req_type, offset, write_data, source_levels, input ready);
    modport sink   (input valid, req_type, offset, write_data, source_levels, output ready);
endinterface

interface pic_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic        access_error;
    logic [3:0]  context_request;

    modport source (output valid, read_data, access_error, context_request, input ready);
    modport sink   (input valid, read_data, access_error, context_request, output ready);
endinterface

// ===== rtl/pic_front.sv =====
// ----------------------------------------------------------------------------
// pic_front
// Accepts requests and decodes the register map into a command.
// ----------------------------------------------------------------------------
module pic_front #(
    parameter int NUM_SOURCES  = 64,
    parameter int NUM_CONTEXTS = 4
) (
    pic_in_if.sink          i_in,
    input  logic            i_q_ready,
    input  logic            i_clearing,
    output pic_pkg::t_qchan o_push
);
    import pic_pkg::*;

    localparam int SRC_WORDS = (NUM_SOURCES + 31) / 32;

    logic [OFF_W-1:0] off;
    logic [OFF_W-1:0] rel;
    t_entry           ent;

    always_comb begin
        off = {i_in.offset[OFF_W-1:2], 2'b00};
        rel = '0;
        ent = '0;
        ent.wr     = (i_in.req_type == REQ_WRITE);
        ent.data   = i_in.write_data;
        ent.levels = i_in.source_levels;
        ent.kind   = K_NOP;
        if (i_in.req_type == REQ_LEVELS) begin
            ent.kind = K_LEVELS;
        end else if (i_in.req_type == REQ_READ || i_in.req_type == REQ_WRITE) begin
            if (off < PENDING_BASE) begin
                if (32'(off[OFF_W-1:2]) >= 32'(NUM_SOURCES)) begin
                    ent.kind = K_ERR;
                end else if (off[OFF_W-1:2] != '0) begin
                    ent.kind = K_PRIO;
                    ent.idx  = off[IDX_W+1:2];
                end
            end else if (off < ENABLE_BASE) begin
                if (32'(off[11:2]) >= 32'(SRC_WORDS)) begin
                    ent.kind = K_ERR;
                end else begin
                    ent.kind = K_PEND;
                    ent.idx  = off[IDX_W+1:2];
                end
            end else if (off < CONTEXT_BASE) begin
                rel = off - ENABLE_BASE;
                if (32'(rel[OFF_W-1:7]) >= 32'(NUM_CONTEXTS) ||
                    32'(rel[6:2]) >= 32'(SRC_WORDS)) begin
                    ent.kind = K_ERR;
                end else begin
                    ent.kind = K_ENAB;
                    ent.ctx  = rel[CTX_W+6:7];
                    ent.idx  = IDX_W'(rel[6:2]);
                end
            end else begin
                rel = off - CONTEXT_BASE;
                if (32'(rel[OFF_W-1:12]) >= 32'(NUM_CONTEXTS) ||
                    (rel[11:0] != REG_THRESH && rel[11:0] != REG_CLAIM)) begin
                    ent.kind = K_ERR;
                end else begin
                    ent.kind = (rel[11:0] == REG_THRESH) ? K_THRESH : K_CLAIM;
                    ent.ctx  = rel[CTX_W+11:12];
                end
            end
        end
    end

    assign i_in.ready   = i_q_ready && !i_clearing;
    assign o_push.valid = i_in.valid && i_q_ready && !i_clearing;
    assign o_push.entry = ent;

endmodule

// ===== rtl/pic_queue.sv =====
// ----------------------------------------------------------------------------
// pic_queue
// Two-entry command queue between decode and execution.
// ----------------------------------------------------------------------------
module pic_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pic_pkg::t_qchan i_push,
    output logic            o_ready,
    output pic_pkg::t_qchan o_head,
    input  logic            i_pop
);
    import pic_pkg::*;

    t_entry      r_mem [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;
    logic        push;
    logic        pop;

    assign o_ready      = (r_cnt != 2'd2);
    assign push         = i_push.valid && o_ready;
    assign pop          = i_pop && (r_cnt != 2'd0);
    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.entry = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push.entry;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

endmodule

// ===== rtl/pic_back.sv =====
// ----------------------------------------------------------------------------
// pic_back
// Executes commands, runs the gateways and rescans for the best source.
// ----------------------------------------------------------------------------
module pic_back #(
    parameter int NUM_SOURCES   = 64,
    parameter int NUM_CONTEXTS  = 4,
    parameter int PRIORITY_BITS = 3
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pic_pkg::t_qchan i_head,
    output logic            o_pop,
    output logic            o_clearing,
    pic_out_if.source       o_out
);
    import pic_pkg::*;

    localparam int SW = $clog2(NUM_SOURCES);
    localparam int CW = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
    localparam int PB = PRIORITY_BITS;
    localparam int N  = NUM_SOURCES;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_EXEC, S_GATE, S_SCAN, S_LAST, S_OUT
    } t_state;

    t_state             r_state;
    t_entry             r_ent;
    logic [SW-1:0]      r_scan;
    logic [SW-1:0]      r_cmp_id;
    logic               r_cmp_v;
    logic [N-1:0]       r_pend;
    logic [N-1:0]       r_insvc;
    logic [N-1:0]       r_en    [NUM_CONTEXTS];
    logic [PB-1:0]      r_thr   [NUM_CONTEXTS];
    logic [SW-1:0]      r_best  [NUM_CONTEXTS];
    logic [PB-1:0]      r_bprio [NUM_CONTEXTS];
    logic [LVL_W-1:0]   r_lvl;
    logic [DATA_W-1:0]  r_rd;
    logic               r_err;

    // priority store, cleared by a sweep after reset
    logic [PB-1:0]      r_prio_mem [N];
    logic [PB-1:0]      r_prio_q;
    logic               mem_we;
    logic [SW-1:0]      mem_wa;
    logic [PB-1:0]      mem_wd;
    logic [SW-1:0]      mem_ra;

    logic [CW-1:0]      c_idx;
    logic [N-1:0]       lvl_ext;
    logic [DATA_W-1:0]  pend_word;
    logic [DATA_W-1:0]  en_word;
    logic [SW-1:0]      cmpl_id;
    logic               cmpl_ok;
    int                 id;

    assign c_idx   = r_ent.ctx[CW-1:0];
    assign cmpl_id = r_ent.data[SW-1:0];
    assign cmpl_ok = (r_ent.data != '0) && (r_ent.data < DATA_W'(N)) && r_en[c_idx][cmpl_id];

    always_comb begin
        mem_we = (r_state == S_CLEAR) ||
                 (r_state == S_EXEC && r_ent.kind == K_PRIO && r_ent.wr);
        mem_wa = (r_state == S_CLEAR) ? r_scan : r_ent.idx[SW-1:0];
        mem_wd = (r_state == S_CLEAR) ? '0 : r_ent.data[PB-1:0];
        mem_ra = (r_state == S_SCAN) ? r_scan : r_ent.idx[SW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_prio_mem[mem_wa] <= mem_wd;
        end
        r_prio_q <= r_prio_mem[mem_ra];
    end

    // word views of pending and enable bits, plus line levels widened
    always_comb begin
        pend_word = '0;
        en_word   = '0;
        id        = 0;
        for (int b = 0; b < 32; b++) begin
            id = 32 * int'(r_ent.idx) + b;
            if (id < N) begin
                pend_word[b] = r_pend[SW'(id)];
                en_word[b]   = r_en[c_idx][SW'(id)];
            end
        end
        for (int i = 0; i < N; i++) begin
            lvl_ext[i] = (i != 0 && i < LVL_W) ? r_lvl[6'(i)] : 1'b0;
        end
    end

    assign o_pop      = (r_state == S_IDLE) && i_head.valid;
    assign o_clearing = (r_state == S_CLEAR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_scan   <= '0;
            r_cmp_id <= '0;
            r_cmp_v  <= 1'b0;
            r_pend   <= '0;
            r_insvc  <= '0;
            r_lvl    <= '0;
            r_rd     <= '0;
            r_err    <= 1'b0;
            for (int c = 0; c < NUM_CONTEXTS; c++) begin
                r_en[c]    <= '0;
                r_thr[c]   <= '0;
                r_best[c]  <= '0;
                r_bprio[c] <= '0;
            end
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_scan <= r_scan + 1'b1;
                    if (32'(r_scan) == 32'(N - 1)) begin
                        r_scan  <= '0;
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_head.valid) begin
                        r_ent   <= i_head.entry;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_rd  <= '0;
                    r_err <= 1'b0;
                    case (r_ent.kind)
                        K_LEVELS: r_lvl <= r_ent.levels;
                        K_ERR:    r_err <= 1'b1;
                        K_PEND: begin
                            if (!r_ent.wr) r_rd <= pend_word;
                        end
                        K_ENAB: begin
                            if (r_ent.wr) begin
                                for (int b = 0; b < 32; b++) begin
                                    if (32 * int'(r_ent.idx) + b < N &&
                                        32 * int'(r_ent.idx) + b != 0) begin
                                        r_en[c_idx][SW'(32 * int'(r_ent.idx) + b)] <=
                                            r_ent.data[b];
                                    end
                                end
                            end else begin
                                r_rd <= en_word;
                            end
                        end
                        K_THRESH: begin
                            if (r_ent.wr) r_thr[c_idx] <= r_ent.data[PB-1:0];
                            else          r_rd <= DATA_W'(r_thr[c_idx]);
                        end
                        K_CLAIM: begin
                            if (!r_ent.wr) begin
                                // best id is still valid from the last rescan
                                r_rd <= DATA_W'(r_best[c_idx]);
                                if (r_best[c_idx] != '0) begin
                                    r_pend[r_best[c_idx]]  <= 1'b0;
                                    r_insvc[r_best[c_idx]] <= 1'b1;
                                end
                            end else if (cmpl_ok) begin
                                r_insvc[cmpl_id] <= 1'b0;
                            end
                        end
                        default: ;
                    endcase
                    r_state <= S_GATE;
                end
                S_GATE: begin
                    if (r_ent.kind == K_PRIO && !r_ent.wr) begin
                        r_rd <= DATA_W'(r_prio_q);
                    end
                    r_pend  <= r_pend | (lvl_ext & ~r_insvc);
                    r_scan  <= '0;
                    r_cmp_v <= 1'b0;
                    for (int c = 0; c < NUM_CONTEXTS; c++) begin
                        r_best[c]  <= '0;
                        r_bprio[c] <= r_thr[c];
                    end
                    r_state <= S_SCAN;
                end
                S_SCAN, S_LAST: begin
                    // compare lags the address by the registered memory read
                    if (r_cmp_v) begin
                        for (int c = 0; c < NUM_CONTEXTS; c++) begin
                            if (r_pend[r_cmp_id] && r_en[c][r_cmp_id] &&
                                r_prio_q > r_bprio[c]) begin
                                r_best[c]  <= r_cmp_id;
                                r_bprio[c] <= r_prio_q;
                            end
                        end
                    end
                    r_cmp_id <= r_scan;
                    r_cmp_v  <= 1'b1;
                    if (r_state == S_LAST) begin
                        r_state <= S_OUT;
                    end else begin
                        r_scan <= r_scan + 1'b1;
                        if (32'(r_scan) == 32'(N - 1)) r_state <= S_LAST;
                    end
                end
                S_OUT: begin
                    if (o_out.ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid        = (r_state == S_OUT);
    assign o_out.read_data    = r_rd;
    assign o_out.access_error = r_err;

    always_comb begin
        o_out.context_request = '0;
        for (int c = 0; c < REQ_W; c++) begin
            if (c < NUM_CONTEXTS) begin
                o_out.context_request[c] = (r_best[c % NUM_CONTEXTS] != '0);
            end
        end
    end

endmodule

// ===== rtl/platform_interrupt_controller_core.sv =====
// ----------------------------------------------------------------------------
// platform_interrupt_controller_core
// Level-triggered platform interrupt controller with the standard map.
// ----------------------------------------------------------------------------
// Usage: requests arrive on i_in (bus read, bus write or a new set of line
// levels); one result per request leaves on o_out with read data, an
// access error flag and the request bit of each context after the request.
// A transfer happens when valid and ready are both high.
// A decoder classifies each request into a two-entry queue; the executor
// performs it, runs the gateways and rescans all sources for every context
// at one source per cycle through the priority memory.
// The executor starts the next request only after the result of the last
// one has been accepted on o_out.
// Reset: synchronous, active low. After reset a sweep zeroes the priority
// memory; requests are not taken during the sweep.
// When the receiver stalls the result is held in the output register; up
// to two further requests are taken into the queue meanwhile.
// ----------------------------------------------------------------------------
module platform_interrupt_controller_core #(
    parameter int NUM_SOURCES   = 64,
    parameter int NUM_CONTEXTS  = 4,
    parameter int PRIORITY_BITS = 3
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pic_in_if.sink     i_in,
    pic_out_if.source  o_out
);
    import pic_pkg::*;

    t_qchan push;
    t_qchan head;
    logic   q_ready;
    logic   pop;
    logic   clearing;

    pic_front #(
        .NUM_SOURCES  (NUM_SOURCES),
        .NUM_CONTEXTS (NUM_CONTEXTS)
    ) u_front (
        .i_in       (i_in),
        .i_q_ready  (q_ready),
        .i_clearing (clearing),
        .o_push     (push)
    );

    pic_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_ready (q_ready),
        .o_head  (head),
        .i_pop   (pop)
    );

    pic_back #(
        .NUM_SOURCES   (NUM_SOURCES),
        .NUM_CONTEXTS  (NUM_CONTEXTS),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .o_pop      (pop),
        .o_clearing (clearing),
        .o_out      (o_out)
    );

endmodule

// ===== tb/platform_interrupt_controller_core_tb.sv =====
// ----------------------------------------------------------------------------
// platform_interrupt_controller_core_tb
// Drives bus reads, bus writes and line level updates into the interrupt
// controller with random idling on both sides, predicts every result from a
// behavioural copy of the register map, and compares each result by field.
// ----------------------------------------------------------------------------
module platform_interrupt_controller_core_tb;
    import pic_pkg::*;

    localparam int NSRC  = 64;
    localparam int NCTX  = 4;
    localparam int PMASK = 7;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [31:0] rdata;
        logic        err;
        logic [3:0]  req;
    } t_result;

    class plic_scoreboard;
        logic [2:0]  prio [NSRC];
        logic [63:0] pend;
        logic [63:0] insvc;
        logic [63:0] enab [NCTX];
        logic [2:0]  thresh [NCTX];
        logic [63:0] levels;
        t_result     pending_results [$];
        int          fails;

        function void clear();
            for (int i = 0; i < NSRC; i++) prio[i] = '0;
            for (int c = 0; c < NCTX; c++) begin
                enab[c] = '0;
                thresh[c] = '0;
            end
            pend = '0;
            insvc = '0;
            levels = '0;
            fails = 0;
        endfunction

        function int winner(int ctx);
            int best;
            int bp;
            best = 0;
            bp = int'(thresh[ctx]);
            for (int id = 1; id < NSRC; id++)
                if (pend[id] && enab[ctx][id] && int'(prio[id]) > bp) begin
                    best = id;
                    bp = int'(prio[id]);
                end
            return best;
        endfunction

        function void note_request(logic [1:0] rt, logic [25:0] off_in,
                                   logic [31:0] wd, logic [63:0] lv);
            t_result     r;
            logic [25:0] off;
            logic        wr;
            int          idx;
            int          ctx;
            int          w;
            int          rg;
            r = '0;
            off = {off_in[25:2], 2'b00};
            wr = (rt == REQ_WRITE);
            if (rt == REQ_LEVELS) begin
                levels = lv;
            end else if (rt == REQ_READ || rt == REQ_WRITE) begin
                if (off < PENDING_BASE) begin
                    idx = int'(off >> 2);
                    if (idx >= NSRC) r.err = 1;
                    else if (idx != 0) begin
                        if (wr) prio[idx] = wd[2:0];
                        else r.rdata = 32'(prio[idx]);
                    end
                end else if (off < ENABLE_BASE) begin
                    w = int'((off - PENDING_BASE) >> 2);
                    if (w >= 2) r.err = 1;
                    else if (!wr) r.rdata = pend[w*32 +: 32];
                end else if (off < CONTEXT_BASE) begin
                    ctx = int'((off - ENABLE_BASE) >> 7);
                    w = int'(((off - ENABLE_BASE) & 'h7f) >> 2);
                    if (ctx >= NCTX || w >= 2) r.err = 1;
                    else if (wr) begin
                        enab[ctx][w*32 +: 32] = wd;
                        enab[ctx][0] = 1'b0;
                    end else r.rdata = enab[ctx][w*32 +: 32];
                end else begin
                    ctx = int'((off - CONTEXT_BASE) >> 12);
                    rg = int'((off - CONTEXT_BASE) & 'hfff);
                    if (ctx >= NCTX || (rg != REG_THRESH && rg != REG_CLAIM)) r.err = 1;
                    else if (rg == REG_THRESH) begin
                        if (wr) thresh[ctx] = wd[2:0];
                        else r.rdata = 32'(thresh[ctx]);
                    end else if (!wr) begin
                        idx = winner(ctx);
                        if (idx != 0) begin
                            pend[idx] = 1'b0;
                            insvc[idx] = 1'b1;
                        end
                        r.rdata = 32'(idx);
                    end else if (wd != 0 && wd < NSRC && enab[ctx][wd[5:0]]) begin
                        insvc[wd[5:0]] = 1'b0;
                    end
                end
            end
            // gateways: a high line re-arms pending once out of service
            for (int id = 1; id < NSRC; id++)
                if (levels[id] && !insvc[id]) pend[id] = 1'b1;
            for (int c = 0; c < NCTX; c++)
                r.req[c] = (winner(c) != 0);
            pending_results.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result exp_r;
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: rdata %h", got.rdata);
                fails++;
                return;
            end
            exp_r = pending_results.pop_front();
            if (got.rdata !== exp_r.rdata) begin
                $error("read_data expected %h actual %h", exp_r.rdata, got.rdata);
                fails++;
            end
            if (got.err !== exp_r.err) begin
                $error("access_error expected %b actual %b", exp_r.err, got.err);
                fails++;
            end
            if (got.req !== exp_r.req) begin
                $error("context_request expected %b actual %b", exp_r.req, got.req);
                fails++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    pic_in_if  req_ch ();
    pic_out_if res_ch ();
    plic_scoreboard sb;
    int  idle_cycles;
    bit  long_hold;

    platform_interrupt_controller_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch.sink),
        .o_out   (res_ch.source)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function int gap_len();
        if ($urandom_range(0, 3) != 0) return 0;
        if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // transfers are sampled at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) idle_cycles <= 0;
        else begin
            if (req_ch.valid && req_ch.ready)
                sb.note_request(req_ch.req_type, req_ch.offset,
                                req_ch.write_data, req_ch.source_levels);
            if (res_ch.valid && res_ch.ready)
                sb.check_result({res_ch.read_data, res_ch.access_error,
                                 res_ch.context_request});
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off when asked
    initial begin
        int n;
        res_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                res_ch.ready <= 1'b0;
                for (int k = 0; k < 400; k++) @(negedge i_clk);
                long_hold = 0;
            end
            n = gap_len();
            if (n == 0) res_ch.ready <= 1'b1;
            else begin
                res_ch.ready <= 1'b0;
                repeat (n - 1) @(negedge i_clk);
            end
        end
    end

    // valid stays high into the next request unless a gap is drawn
    task automatic send(logic [1:0] rt, logic [25:0] off, logic [31:0] wd,
                        logic [63:0] lv);
        int n;
        n = gap_len();
        if (n > 0) begin
            req_ch.valid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.req_type      <= rt;
        req_ch.offset        <= off;
        req_ch.write_data    <= wd;
        req_ch.source_levels <= lv;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function logic [25:0] any_offset();
        logic [25:0] o;
        case ($urandom_range(0, 9))
            0: o = 26'($urandom_range(0, NSRC + 3) * 4);
            1: o = PENDING_BASE + 26'($urandom_range(0, 3) * 4);
            2: o = ENABLE_BASE + 26'($urandom_range(0, NCTX) * 'h80)
                   + 26'($urandom_range(0, 2) * 4);
            3, 4, 5: o = CONTEXT_BASE + 26'($urandom_range(0, NCTX - 1) * 'h1000) + 26'h4;
            6: o = CONTEXT_BASE + 26'($urandom_range(0, NCTX) * 'h1000)
                   + 26'($urandom_range(0, 3) * 4);
            7: o = 26'($urandom_range(0, NSRC - 1) * 4);
            8: o = ENABLE_BASE + 26'($urandom_range(0, NCTX - 1) * 'h80)
                   + 26'($urandom_range(0, 1) * 4);
            default: o = 26'($urandom());
        endcase
        if ($urandom_range(0, 7) == 0) o[1:0] = 2'($urandom());
        return o;
    endfunction

    initial begin
        logic [1:0]  rt;
        logic [25:0] off;
        logic [31:0] wd;
        sb = new();
        sb.clear();
        long_hold = 0;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_READ;
        req_ch.offset = '0;
        req_ch.write_data = '0;
        req_ch.source_levels = '0;
        i_rst_n = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: map edges, source zero, wide values, claims, strays
        send(REQ_WRITE, 26'h0, 32'hffff_ffff, '0);
        send(REQ_READ, 26'h0, '0, '0);
        send(REQ_WRITE, 26'h4, 32'hffff_ffff, '0);
        send(REQ_WRITE, 26'((NSRC - 1) * 4), 32'h5, '0);
        send(REQ_READ, 26'(NSRC * 4), '0, '0);
        send(REQ_WRITE, PENDING_BASE, 32'hffff_ffff, '0);
        send(REQ_READ, PENDING_BASE + 26'h8, '0, '0);
        send(REQ_WRITE, ENABLE_BASE, 32'hffff_ffff, '0);
        send(REQ_WRITE, ENABLE_BASE + 26'h4, 32'hffff_ffff, '0);
        send(REQ_READ, ENABLE_BASE, '0, '0);
        send(REQ_READ, ENABLE_BASE + 26'h8, '0, '0);
        send(REQ_READ, ENABLE_BASE + 26'(NCTX * 'h80), '0, '0);
        send(REQ_LEVELS, '0, '0, 64'hffff_ffff_ffff_ffff);
        send(REQ_READ, PENDING_BASE + 26'h4, '0, '0);
        send(REQ_WRITE, CONTEXT_BASE, 32'hffff_fffa, '0);
        send(REQ_READ, CONTEXT_BASE + 26'h4, '0, '0);
        send(REQ_WRITE, CONTEXT_BASE, '0, '0);
        send(REQ_READ, CONTEXT_BASE + 26'h7, '0, '0);
        send(REQ_LEVELS, '0, '0, '0);
        send(REQ_WRITE, CONTEXT_BASE + 26'h4, 32'(NSRC - 1), '0);
        send(REQ_WRITE, CONTEXT_BASE + 26'h4, 32'hffff_ffff, '0);
        send(REQ_WRITE, CONTEXT_BASE + 26'h4, 32'h0, '0);
        send(REQ_READ, CONTEXT_BASE + 26'(NCTX * 'h1000), '0, '0);
        send(REQ_READ, CONTEXT_BASE + 26'h8, '0, '0);
        send(REQ_UNKNOWN, 26'h3ff_ffff, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff);

        for (int i = 0; i < 600; i++) begin
            if (i == 300) long_hold = 1;
            off = any_offset();
            wd = $urandom();
            rt = $urandom_range(0, 9) < 5 ? REQ_READ :
                 ($urandom_range(0, 4) == 0 ? REQ_LEVELS : REQ_WRITE);
            if ($urandom_range(0, 40) == 0) rt = REQ_UNKNOWN;
            // completes mostly name a real source
            if (rt == REQ_WRITE && off[11:0] == REG_CLAIM && $urandom_range(0, 3) != 0)
                wd = $urandom_range(1, NSRC - 1);
            send(rt, off, wd, {$urandom(), $urandom()});
        end
        req_ch.valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.fails == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/pic_pkg.sv
rtl/pic_if.sv
rtl/pic_front.sv
rtl/pic_queue.sv
rtl/pic_back.sv
rtl/platform_interrupt_controller_core.sv
tb/platform_interrupt_controller_core_tb.sv
